// ===== sv/rmd_pkg.sv =====
// ----------------------------------------------------------------------------
// rmd_pkg
// Shared types and constants of the RPC record-mark deframer.
// ----------------------------------------------------------------------------
package rmd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned LenW    = 31;
  localparam int unsigned CountW  = 32;
  localparam int unsigned ShiftW  = 24;
  localparam int unsigned IdxW    = 2;

  localparam logic [LenW-1:0]   LEN_MASK  = 31'h7FFF_FFFF;
  localparam logic [CountW-1:0] COUNT_MAX = 32'hFFFF_FFFF;
  localparam logic [IdxW-1:0]   IDX_LAST  = 2'd3;

  typedef struct packed {
    logic [ByteW-1:0]  payload_byte;
    logic              byte_present;
    logic              message_end;
    logic [CountW-1:0] message_length;
  } result_t;

  // One step of the parser: whether it produces a result, and the result.
  typedef struct packed {
    logic    emit;
    result_t res;
  } parse_out_t;

endpackage

// ===== sv/rmd_if.sv =====
// ----------------------------------------------------------------------------
// rmd_if
// Valid/ready channels of the deframer: the byte stream in, the results out.
// ----------------------------------------------------------------------------
interface rmd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink   (input valid, input stream_byte, output ready);
endinterface

interface rmd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  payload_byte;
  logic        byte_present;
  logic        message_end;
  logic [31:0] message_length;

  modport source (output valid, output payload_byte, output byte_present,
                  output message_end, output message_length, input ready);
  modport sink   (input valid, input payload_byte, input byte_present,
                  input message_end, input message_length, output ready);
endinterface

// ===== sv/rmd_in_stage.sv =====
// ----------------------------------------------------------------------------
// rmd_in_stage
// Input register: captures one stream byte per transfer.
// ----------------------------------------------------------------------------
module rmd_in_stage (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_vld,
  input  logic [rmd_pkg::ByteW-1:0]  in_data,
  output logic                       in_rdy,
  input  logic                       take,
  output logic                       held_vld,
  output logic [rmd_pkg::ByteW-1:0]  held_data
);

  logic                      valid;
  logic [rmd_pkg::ByteW-1:0] data;

  assign in_rdy    = !valid || take;
  assign held_vld  = valid;
  assign held_data = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_rdy) begin
      valid <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy && in_vld) begin
      data <= in_data;
    end
  end

endmodule

// ===== sv/rmd_parse.sv =====
// ----------------------------------------------------------------------------
// rmd_parse
// Record-mark parser: collects markers, counts fragment and message bytes.
// ----------------------------------------------------------------------------
module rmd_parse (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      step,
  input  logic [rmd_pkg::ByteW-1:0] data,
  output rmd_pkg::parse_out_t       pout
);

  logic [rmd_pkg::IdxW-1:0]   marker_byte_index, marker_byte_index_next;
  logic [rmd_pkg::ShiftW-1:0] marker_shift, marker_shift_next;
  logic                       in_payload, in_payload_next;
  logic [rmd_pkg::LenW-1:0]   fragment_remaining, fragment_remaining_next;
  logic                       fragment_is_last, fragment_is_last_next;
  logic [rmd_pkg::CountW-1:0] message_count, message_count_next;

  logic [rmd_pkg::CountW-1:0] count_inc;
  logic [rmd_pkg::LenW-1:0]   rem_dec;
  logic [rmd_pkg::LenW-1:0]   marker_len;
  logic                       marker_last;

  assign count_inc   = (message_count == rmd_pkg::COUNT_MAX) ? message_count
                                                             : message_count + 1'b1;
  assign rem_dec     = (fragment_remaining - 1'b1) & rmd_pkg::LEN_MASK;
  assign marker_len  = {marker_shift[rmd_pkg::ShiftW-2:0], data};
  assign marker_last = marker_shift[rmd_pkg::ShiftW-1];

  always_comb begin
    marker_byte_index_next  = marker_byte_index;
    marker_shift_next       = marker_shift;
    in_payload_next         = in_payload;
    fragment_remaining_next = fragment_remaining;
    fragment_is_last_next   = fragment_is_last;
    message_count_next      = message_count;
    pout                    = '0;

    if (!in_payload) begin
      if (marker_byte_index != rmd_pkg::IDX_LAST) begin
        marker_shift_next      = {marker_shift[rmd_pkg::ShiftW-rmd_pkg::ByteW-1:0], data};
        marker_byte_index_next = marker_byte_index + 1'b1;
      end else begin
        marker_byte_index_next = '0;
        marker_shift_next      = '0;
        if (marker_len == '0) begin
          // empty last fragment closes the message without a byte
          if (marker_last) begin
            pout.emit               = 1'b1;
            pout.res.message_end    = 1'b1;
            pout.res.message_length = message_count;
            message_count_next      = '0;
          end
        end else begin
          in_payload_next         = 1'b1;
          fragment_remaining_next = marker_len;
          fragment_is_last_next   = marker_last;
        end
      end
    end else begin
      message_count_next      = count_inc;
      fragment_remaining_next = rem_dec;
      pout.emit               = 1'b1;
      pout.res.payload_byte   = data;
      pout.res.byte_present   = 1'b1;
      pout.res.message_length = count_inc;
      if (rem_dec == '0) begin
        in_payload_next       = 1'b0;
        fragment_is_last_next = 1'b0;
        pout.res.message_end  = fragment_is_last;
        if (fragment_is_last) begin
          message_count_next = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      marker_byte_index  <= '0;
      marker_shift       <= '0;
      in_payload         <= 1'b0;
      fragment_remaining <= '0;
      fragment_is_last   <= 1'b0;
      message_count      <= '0;
    end else if (step) begin
      marker_byte_index  <= marker_byte_index_next;
      marker_shift       <= marker_shift_next;
      in_payload         <= in_payload_next;
      fragment_remaining <= fragment_remaining_next;
      fragment_is_last   <= fragment_is_last_next;
      message_count      <= message_count_next;
    end
  end

endmodule

// ===== sv/rmd_out_reg.sv =====
// ----------------------------------------------------------------------------
// rmd_out_reg
// Result register: holds one result until the sink takes the transfer.
// ----------------------------------------------------------------------------
module rmd_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  rmd_pkg::result_t    res_in,
  output logic                room,
  rmd_out_if.source           result
);

  logic             valid;
  rmd_pkg::result_t res;

  assign room                  = !valid || result.ready;
  assign result.valid          = valid;
  assign result.payload_byte   = res.payload_byte;
  assign result.byte_present   = res.byte_present;
  assign result.message_end    = res.message_end;
  assign result.message_length = res.message_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (room) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (room && load) begin
      res <= res_in;
    end
  end

endmodule

// ===== sv/rpc_record_mark_deframer.sv =====
// ----------------------------------------------------------------------------
// rpc_record_mark_deframer
// Strips RPC record markers from a byte stream and delivers message bytes.
// ----------------------------------------------------------------------------
// One stream byte is taken per clock when the result side keeps up; a byte
// passes an input register and then the result register, and its result is
// valid once the result register has loaded it. Per byte the parser does one
// 32-bit saturating increment and one 31-bit decrement and zero compare, which
// sets the clock path. Marker bytes and empty non-last fragments give no
// result; an empty last fragment gives one result with byte_present low.
module rpc_record_mark_deframer (
  input  logic      clk,
  input  logic      rst,
  rmd_in_if.sink    stream,
  rmd_out_if.source result
);

  logic                      held_vld;
  logic [rmd_pkg::ByteW-1:0] held_data;
  logic                      room;
  logic                      step;
  rmd_pkg::parse_out_t       pout;

  assign step = held_vld && room;

  rmd_in_stage u_in (
    .clk       (clk),
    .rst       (rst),
    .in_vld    (stream.valid),
    .in_data   (stream.stream_byte),
    .in_rdy    (stream.ready),
    .take      (step),
    .held_vld  (held_vld),
    .held_data (held_data)
  );

  rmd_parse u_parse (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .data (held_data),
    .pout (pout)
  );

  rmd_out_reg u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (step && pout.emit),
    .res_in (pout.res),
    .room   (room),
    .result (result)
  );

`ifndef SYNTHESIS
  a_empty_is_end: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.byte_present |-> result.message_end)
    else $error("result without a byte must close a message");

  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.byte_present |-> result.message_length != 32'd0)
    else $error("payload byte with zero message length");

  a_stall_held: assert property (@(posedge clk) disable iff (rst)
    !stream.ready |-> held_vld && !room)
    else $error("input stalled without a held byte blocked by the result side");

  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !result.valid && !held_vld)
    else $error("pipeline not empty after reset");
`endif

endmodule

// ===== tb/sv/tb_rpc_record_mark_deframer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rpc_record_mark_deframer
// Self-checking testbench of the RPC record-mark deframer. Messages built from
// record-marked fragments are pushed in byte by byte; a scoreboard works out
// the expected payload bytes, end flags and message lengths, and checks every
// result transfer in order, under random idling on both channels.
// ----------------------------------------------------------------------------
module tb_rpc_record_mark_deframer;

  typedef logic [rmd_pkg::LenW-1:0] frag_len_t;

  localparam int unsigned                CycleLimit  = 400000;
  localparam int unsigned                ItemTarget  = 900;
  localparam int unsigned                HoldCycles  = 300;
  localparam int unsigned                DrainCycles = 16;
  localparam logic [rmd_pkg::CountW-1:0] LAST_FLAG   = 32'h8000_0000;

  class deframe_scoreboard;
    rmd_pkg::result_t               pending_results[$];
    int unsigned                    errors;
    logic [rmd_pkg::IdxW-1:0]       mark_idx;
    logic [rmd_pkg::ShiftW-1:0]     mark_sr;
    logic                           in_payload;
    logic [rmd_pkg::LenW-1:0]       frag_left;
    logic                           frag_last;
    logic [rmd_pkg::CountW-1:0]     msg_count;

    function new();
      errors     = 0;
      mark_idx   = '0;
      mark_sr    = '0;
      in_payload = 1'b0;
      frag_left  = '0;
      frag_last  = 1'b0;
      msg_count  = '0;
    endfunction

    // Advance the deframer state by one stream byte and queue its result.
    function void take_stream_byte(logic [rmd_pkg::ByteW-1:0] b);
      rmd_pkg::result_t           r;
      logic [rmd_pkg::CountW-1:0] marker;
      if (!in_payload) begin
        if (mark_idx != rmd_pkg::IDX_LAST) begin
          mark_sr  = {mark_sr[rmd_pkg::ShiftW-9:0], b};
          mark_idx = mark_idx + 1'b1;
          return;
        end
        marker   = {mark_sr, b};
        mark_idx = '0;
        mark_sr  = '0;
        if (marker[rmd_pkg::LenW-1:0] == '0) begin
          if ((marker & LAST_FLAG) != '0) begin
            r.payload_byte   = '0;
            r.byte_present   = 1'b0;
            r.message_end    = 1'b1;
            r.message_length = msg_count;
            pending_results  = {pending_results, r};
            msg_count = '0;
          end
          return;
        end
        in_payload = 1'b1;
        frag_left  = marker[rmd_pkg::LenW-1:0] & rmd_pkg::LEN_MASK;
        frag_last  = marker[rmd_pkg::CountW-1];
        return;
      end
      if (msg_count != rmd_pkg::COUNT_MAX) msg_count = msg_count + 1'b1;
      frag_left        = frag_left - 1'b1;
      r.payload_byte   = b;
      r.byte_present   = 1'b1;
      r.message_end    = 1'b0;
      r.message_length = msg_count;
      if (frag_left == '0) begin
        r.message_end = frag_last;
        in_payload    = 1'b0;
        frag_last     = 1'b0;
        if (r.message_end) msg_count = '0;
      end
      pending_results = {pending_results, r};
    endfunction

    function void check_result(rmd_pkg::result_t got);
      rmd_pkg::result_t want;
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing expected: byte %0h len %0d",
               got.payload_byte, got.message_length);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (got.payload_byte !== want.payload_byte) begin
        $error("payload_byte: expected %0h, got %0h", want.payload_byte, got.payload_byte);
        errors++;
      end
      if (got.byte_present !== want.byte_present) begin
        $error("byte_present: expected %0b, got %0b", want.byte_present, got.byte_present);
        errors++;
      end
      if (got.message_end !== want.message_end) begin
        $error("message_end: expected %0b, got %0b", want.message_end, got.message_end);
        errors++;
      end
      if (got.message_length !== want.message_length) begin
        $error("message_length: expected %0d, got %0d",
               want.message_length, got.message_length);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  rmd_in_if  stream_if ();
  rmd_out_if result_if ();

  rpc_record_mark_deframer i_dut (
    .clk    (clk),
    .rst    (rst),
    .stream (stream_if),
    .result (result_if)
  );

  deframe_scoreboard sb = new();

  int unsigned cycles     = 0;
  int unsigned bytes_sent = 0;
  bit          idle_on    = 1'b1;
  bit          hold_req   = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("** rpc_record_mark_deframer: FAILED **");
      $finish;
    end
  end

  // Note accepted bytes before checking results so one edge stays ordered.
  always @(posedge clk) begin
    rmd_pkg::result_t got;
    if (!rst) begin
      if (stream_if.valid && stream_if.ready) sb.take_stream_byte(stream_if.stream_byte);
      if (result_if.valid && result_if.ready) begin
        got.payload_byte   = result_if.payload_byte;
        got.byte_present   = result_if.byte_present;
        got.message_end    = result_if.message_end;
        got.message_length = result_if.message_length;
        sb.check_result(got);
      end
    end
  end

  // Result side: random short stalls, one long hold-off on request.
  initial begin
    result_if.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        result_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        result_if.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
      result_if.ready <= 1'b1;
      @(posedge clk);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      stream_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    stream_if.valid       <= 1'b1;
    stream_if.stream_byte <= b;
    do @(posedge clk); while (!stream_if.ready);
    bytes_sent++;
  endtask

  task automatic send_marker(input logic last, input frag_len_t len);
    logic [31:0] marker;
    marker = {last, len};
    send_byte(marker[31:24]);
    send_byte(marker[23:16]);
    send_byte(marker[15:8]);
    send_byte(marker[7:0]);
  endtask

  task automatic send_random_bytes(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic send_random_message();
    int unsigned nfrag;
    int unsigned pick;
    int unsigned len;
    nfrag = $urandom_range(1, 4);
    for (int unsigned f = 0; f < nfrag; f++) begin
      pick = $urandom_range(0, 99);
      if (pick < 10)      len = 0;
      else if (pick < 90) len = $urandom_range(1, 12);
      else                len = $urandom_range(13, 300);
      send_marker(f == nfrag - 1, frag_len_t'(len));
      send_random_bytes(len);
    end
  endtask

  initial begin
    bit held;
    bit drained;
    held    = 1'b0;
    drained = 1'b0;
    stream_if.valid       <= 1'b0;
    stream_if.stream_byte <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty message: one result with no byte and zero length.
    send_marker(1'b1, '0);
    // Two-byte message at the byte extremes.
    send_marker(1'b1, frag_len_t'(2));
    send_byte(8'h00);
    send_byte(8'hFF);
    // Empty middle fragment is dropped; empty last fragment closes the message.
    send_marker(1'b0, '0);
    send_marker(1'b0, frag_len_t'(2));
    send_byte(8'hAA);
    send_byte(8'h55);
    send_marker(1'b1, '0);

    while (bytes_sent < ItemTarget) begin
      if (!held && bytes_sent > 300) begin
        held     = 1'b1;
        hold_req = 1'b1;
      end
      if (!drained && bytes_sent > 600) begin
        drained = 1'b1;
        stream_if.valid <= 1'b0;
        do @(posedge clk); while (sb.pending_results.size() != 0);
      end
      if (bytes_sent > 800) idle_on = 1'b0;
      send_random_message();
    end

    // Largest possible last fragment: the block stays in payload from here on.
    send_marker(1'b1, rmd_pkg::LEN_MASK);
    send_random_bytes(40);
    stream_if.valid <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (sb.errors == 0) begin
      $display("** rpc_record_mark_deframer: PASSED **");
    end else begin
      $display("** rpc_record_mark_deframer: FAILED **");
    end
    $finish;
  end

endmodule
